// ----- rtl/core/bba_pkg.sv -----
// Shared types, codes and reset constants of the bitmap block allocator.
package bba_pkg;

  // Field widths
  localparam int BLK_W  = 13;  // block number as seen on the ports
  localparam int POS_W  = 14;  // scan position and cursor, reach the limit register range
  localparam int CNT_W  = 14;  // free counter
  localparam int CFG_AW = 4;   // APB byte address, four 32-bit registers

  // Map size default
  localparam int MAP_BITS_DEF = 8192;

  // Free counter ceiling
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Register reset values
  localparam logic [BLK_W-1:0] FIRST_RST     = 13'd1;
  localparam logic [POS_W-1:0] LIMIT_RST     = 14'd8192;
  localparam logic             MUTATE_RST    = 1'b1;
  localparam logic [CNT_W-1:0] INIT_FREE_RST = 14'd8191;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_FIRST     = 2'd0;
  localparam logic [1:0] REG_LIMIT     = 2'd1;
  localparam logic [1:0] REG_MUTATE    = 2'd2;
  localparam logic [1:0] REG_INIT_FREE = 2'd3;

  // Operation codes
  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_LOAD  = 2'd2;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_ALREADY_FREE = 3'd1,
    ST_NONE_FREE    = 3'd2,
    ST_REFUSED      = 3'd3,
    ST_RANGE        = 3'd4
  } status_t;

  // Live configuration handed to the engine
  typedef struct packed {
    logic [BLK_W-1:0] first_block;
    logic [POS_W-1:0] block_limit;
    logic             mutate_enable;
  } cfg_t;

  // Finished result from the engine
  typedef struct packed {
    logic             valid;
    logic [BLK_W-1:0] granted_block;
    status_t          status;
    logic [CNT_W-1:0] free_count;
  } res_t;

endpackage

// ----- rtl/core/bitmap_block_allocator_top.sv -----
// Top level of the next-fit bitmap block allocator: registers, engine, output stage.
//
//   channel  direction  handshake            word
//   in_      in         in_valid / in_stall  op, block_number, word_index, word_data
//   out_     out        out_valid/out_stall  granted_block, status, free_count
//   APB      in         psel/penable/pready  paddr[3:2] selects register, 32-bit data
//
// After reset the map is cleared one word a cycle, with in_stall high.
// A load, refused, range-checked or empty-range item goes from S_START to S_DONE, a
// free through S_EVAL, an allocate through one S_EVAL step per map word scanned;
// the scan reads one map word a cycle from the single memory read port.
// One item is in work at a time: the next word can be accepted in the cycle after the
// result moves out, and a stalled output holds the engine in its done state.
module bitmap_block_allocator_top import bba_pkg::*; #(
  parameter int MAP_BITS = MAP_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_op,
  input  logic [BLK_W-1:0]  in_block_number,
  input  logic [7:0]        in_word_index,
  input  logic [31:0]       in_word_data,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BLK_W-1:0]  out_granted_block,
  output logic [2:0]        out_status,
  output logic [CNT_W-1:0]  out_free_count,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t cfg;
  res_t res;
  logic slot_free;

  logic             out_valid_r;
  logic [BLK_W-1:0] out_gnt_r;
  logic [2:0]       out_stat_r;
  logic [CNT_W-1:0] out_cnt_r;

  bba_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bba_engine #(.MAP_BITS(MAP_BITS)) u_engine (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_block_number (in_block_number),
    .in_word_index   (in_word_index),
    .in_word_data    (in_word_data),
    .res             (res),
    .res_take        (slot_free)
  );

  // output register
  assign slot_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (slot_free) begin
      out_valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && res.valid) begin
      out_gnt_r  <= res.granted_block;
      out_stat_r <= res.status;
      out_cnt_r  <= res.free_count;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_granted_block = out_gnt_r;
  assign out_status        = out_stat_r;
  assign out_free_count    = out_cnt_r;

  // checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while previous item still in work");

  a_no_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !res.valid)
    else $error("engine ready with a result still pending");

  a_result_moves_out: assert property (@(posedge clk) disable iff (!rst_n)
    (res.valid && slot_free) |=> (out_valid && (out_status == $past(res.status))))
    else $error("finished result not moved to output register");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status <= ST_RANGE))
    else $error("undefined status code on output");

endmodule

// ----- rtl/core/bba_regs.sv -----
// APB configuration registers of the bitmap block allocator.
module bba_regs import bba_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [BLK_W-1:0] first_r;
  logic [POS_W-1:0] limit_r;
  logic             mutate_r;
  logic [CNT_W-1:0] init_free_r;
  logic             wr;
  logic [1:0]       idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = paddr[CFG_AW-1:2];

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r     <= FIRST_RST;
      limit_r     <= LIMIT_RST;
      mutate_r    <= MUTATE_RST;
      init_free_r <= INIT_FREE_RST;
    end else if (wr) begin
      unique case (idx)
        REG_FIRST:     first_r     <= pwdata[BLK_W-1:0];
        REG_LIMIT:     limit_r     <= pwdata[POS_W-1:0];
        REG_MUTATE:    mutate_r    <= pwdata[0];
        REG_INIT_FREE: init_free_r <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      REG_FIRST:     prdata = 32'(first_r);
      REG_LIMIT:     prdata = 32'(limit_r);
      REG_MUTATE:    prdata = 32'(mutate_r);
      REG_INIT_FREE: prdata = 32'(init_free_r);
      default:       prdata = '0;
    endcase
  end

  assign cfg.first_block   = first_r;
  assign cfg.block_limit   = limit_r;
  assign cfg.mutate_enable = mutate_r;

endmodule

// ----- rtl/core/bba_engine.sv -----
// Allocator sequencer: used-bit map memory, word scan, cursor and free counter.
module bba_engine import bba_pkg::*; #(
  parameter int MAP_BITS = MAP_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_op,
  input  logic [BLK_W-1:0] in_block_number,
  input  logic [7:0]       in_word_index,
  input  logic [31:0]      in_word_data,
  output res_t             res,
  input  logic             res_take
);

  localparam int MAP_WORDS = (MAP_BITS + 31) / 32;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int WW        = POS_W - 5;

  typedef enum logic [4:0] {
    S_CLR   = 5'b00001,
    S_IDLE  = 5'b00010,
    S_START = 5'b00100,
    S_EVAL  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  function automatic logic [AW-1:0] word_of(input logic [POS_W-1:0] p);
    return AW'(p[POS_W-1:5]);
  endfunction

  function automatic logic [4:0] lowest_set(input logic [31:0] v);
    logic [4:0] r;
    r = '0;
    for (int i = 31; i >= 0; i--) begin
      if (v[i]) r = 5'(i);
    end
    return r;
  endfunction

  // used-bit map
  logic [31:0] mem [MAP_WORDS];
  logic [31:0] rdata_r;

  state_t           state_r, state_nxt;
  logic [1:0]       op_r;
  logic [BLK_W-1:0] blk_r;
  logic [7:0]       widx_r;
  logic [31:0]      wdata_r;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] b0_r, b0_nxt;
  logic             phase_b_r, phase_b_nxt;
  logic [POS_W-1:0] cursor_r, cursor_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [BLK_W-1:0] gnt_r, gnt_nxt;
  status_t          stat_r, stat_nxt;
  logic [AW-1:0]    clr_r, clr_nxt;

  logic             we;
  logic [AW-1:0]    wa;
  logic [31:0]      wd;

  logic [POS_W-1:0] lim, first_x, b0;
  logic [WW-1:0]    w;
  logic [POS_W:0]   nxt_ext, g_inc;
  logic [POS_W-1:0] hi, g;
  logic [31:0]      mask_lo, mask_hi, cand;
  logic             found;
  logic [4:0]       k;

  // effective limit and clamped start
  always_comb begin
    if (32'(cfg.block_limit) > MAP_BITS) lim = POS_W'(MAP_BITS);
    else                                 lim = cfg.block_limit;
    first_x = POS_W'(cfg.first_block);
    b0 = ((cursor_r < first_x) || (cursor_r >= lim)) ? first_x : cursor_r;
  end

  // candidate bits of the word in rdata_r
  always_comb begin
    w       = pos_r[POS_W-1:5];
    nxt_ext = {1'b0, w, 5'b0} + (POS_W+1)'(32);
    hi      = phase_b_r ? b0_r : lim;
    mask_lo = 32'hFFFF_FFFF << pos_r[4:0];
    mask_hi = (hi[POS_W-1:5] == w) ? ((32'd1 << hi[4:0]) - 32'd1) : 32'hFFFF_FFFF;
    cand    = ~rdata_r & mask_lo & mask_hi;
    found   = |cand;
    k       = lowest_set(cand);
    g       = {w, k};
    g_inc   = {1'b0, g} + (POS_W+1)'(1);
  end

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    pos_nxt     = pos_r;
    b0_nxt      = b0_r;
    phase_b_nxt = phase_b_r;
    cursor_nxt  = cursor_r;
    count_nxt   = count_r;
    gnt_nxt     = gnt_r;
    stat_nxt    = stat_r;
    clr_nxt     = clr_r;
    we          = 1'b0;
    wa          = word_of(pos_r);
    wd          = rdata_r;
    unique case (state_r)
      S_CLR: begin
        we      = 1'b1;
        wa      = clr_r;
        wd      = '0;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(MAP_WORDS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_nxt = S_START;
      end
      S_START: begin
        gnt_nxt   = '0;
        stat_nxt  = ST_OK;
        state_nxt = S_DONE;
        unique case (op_r)
          OP_ALLOC: begin
            if (!cfg.mutate_enable) begin
              stat_nxt = ST_REFUSED;
            end else if (first_x >= lim) begin
              stat_nxt = ST_NONE_FREE;
            end else begin
              pos_nxt     = b0;
              b0_nxt      = b0;
              phase_b_nxt = 1'b0;
              state_nxt   = S_EVAL;
            end
          end
          OP_FREE: begin
            if (!cfg.mutate_enable) begin
              stat_nxt = ST_REFUSED;
            end else if ((blk_r == '0) || (POS_W'(blk_r) >= lim)) begin
              stat_nxt = ST_RANGE;
            end else begin
              pos_nxt   = POS_W'(blk_r);
              state_nxt = S_EVAL;
            end
          end
          OP_LOAD: begin
            if (32'(widx_r) < MAP_WORDS) begin
              we = 1'b1;
              wa = AW'(widx_r);
              wd = wdata_r;
            end
          end
          default: stat_nxt = ST_REFUSED;
        endcase
      end
      S_EVAL: begin
        if (op_r == OP_FREE) begin
          // free: test and clear one bit
          state_nxt = S_DONE;
          if (!rdata_r[pos_r[4:0]]) begin
            stat_nxt = ST_ALREADY_FREE;
          end else begin
            we = 1'b1;
            wd = rdata_r & ~(32'd1 << pos_r[4:0]);
            if (count_r != CNT_MAX) count_nxt = count_r + CNT_W'(1);
            if (pos_r < cursor_r) cursor_nxt = pos_r;
          end
        end else if (found) begin
          // allocate: take lowest candidate bit
          we         = 1'b1;
          wd         = rdata_r | (32'd1 << k);
          if (count_r != '0) count_nxt = count_r - CNT_W'(1);
          cursor_nxt = (g_inc >= {1'b0, lim}) ? first_x : g_inc[POS_W-1:0];
          gnt_nxt    = g[BLK_W-1:0];
          state_nxt  = S_DONE;
        end else if (!phase_b_r) begin
          // upper segment: cursor up to limit
          if (nxt_ext >= {1'b0, lim}) begin
            if (first_x < b0_r) begin
              phase_b_nxt = 1'b1;
              pos_nxt     = first_x;
            end else begin
              stat_nxt  = ST_NONE_FREE;
              state_nxt = S_DONE;
            end
          end else begin
            pos_nxt = nxt_ext[POS_W-1:0];
          end
        end else begin
          // wrapped segment: first block up to cursor
          if (nxt_ext >= {1'b0, b0_r}) begin
            stat_nxt  = ST_NONE_FREE;
            state_nxt = S_DONE;
          end else begin
            pos_nxt = nxt_ext[POS_W-1:0];
          end
        end
      end
      S_DONE: begin
        if (res_take) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // map memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[word_of(pos_nxt)];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLR;
      clr_r    <= '0;
      cursor_r <= '0;
      count_r  <= INIT_FREE_RST;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      cursor_r <= cursor_nxt;
      count_r  <= count_nxt;
    end
  end

  // payload and scan registers
  always_ff @(posedge clk) begin
    if ((state_r == S_IDLE) && in_valid) begin
      op_r    <= in_op;
      blk_r   <= in_block_number;
      widx_r  <= in_word_index;
      wdata_r <= in_word_data;
    end
    pos_r     <= pos_nxt;
    b0_r      <= b0_nxt;
    phase_b_r <= phase_b_nxt;
    gnt_r     <= gnt_nxt;
    stat_r    <= stat_nxt;
  end

  assign in_stall          = (state_r != S_IDLE);
  assign res.valid         = (state_r == S_DONE);
  assign res.granted_block = gnt_r;
  assign res.status        = stat_r;
  assign res.free_count    = count_r;

endmodule
